[hdl/jrpq_pkg.sv]
// ----------------------------------------------------------------------------
// jrpq_pkg
// shared types and constants for the job request priority queue
// ----------------------------------------------------------------------------
package jrpq_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [19:0] id;
    logic        imm;
    logic [5:0]  prio;
    logic [31:0] time_s;
  } job_t;

  // true if new request a goes in front of stored entry b
  function automatic logic goes_before(input job_t a, input job_t b);
    logic later;
    later = (a.time_s != b.time_s) ? (a.time_s > b.time_s) : (a.id > b.id);
    if (a.imm) begin
      goes_before = b.imm ? later : 1'b1;
    end else if (b.imm) begin
      goes_before = 1'b0;
    end else if (a.prio == b.prio) begin
      goes_before = !later;
    end else begin
      goes_before = a.prio < b.prio;
    end
  endfunction

endpackage

[hdl/job_request_priority_queue.sv]
// ----------------------------------------------------------------------------
// job_request_priority_queue
// sorted job request store with insert, remove-by-id and find-by-id
// ----------------------------------------------------------------------------
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | opcode request_id immediate priority_req submit_time
// out     | out_valid | out_stall | status position occupancy
//
// entries live in one memory with a registered read, kept in service order.
// an item scans the occupied entries one per cycle (read, compare), then for
// insert/remove shifts the tail entry by entry (read, write back); a full
// insert or an unused opcode skips the scan and goes straight to done.
// one item is in work at a time; its result is staged and moves to the
// output register once that register is free, so the next item is taken
// while a result waits. reset clears control only; the memory needs no
// clearing pass.
module job_request_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [19:0] request_id,
  input  logic        immediate,
  input  logic [5:0]  priority_req,
  input  logic [31:0] submit_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  position,
  output logic [6:0]  occupancy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  jrpq_pkg::job_t mem [jrpq_pkg::DEPTH];
  jrpq_pkg::job_t rd_data;
  jrpq_pkg::job_t job;
  logic [1:0] op;
  logic [jrpq_pkg::CW-1:0] count;
  logic [jrpq_pkg::CW-1:0] idx;   // scan / shift pointer
  logic [jrpq_pkg::CW-1:0] pos;   // found position
  logic       rd_pend;            // rd_data is valid for entry idx-1
  logic [jrpq_pkg::AW-1:0] rd_addr;
  logic       wr_en;
  logic [jrpq_pkg::AW-1:0] wr_addr;
  jrpq_pkg::job_t wr_data;
  logic [1:0] res_status;         // staged result until the output is free
  logic [5:0] res_position;

  assign in_stall = (state != S_IDLE);

  // memory: one read, one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  logic [jrpq_pkg::CW-1:0] prev;
  assign prev = idx - 1'b1;
  logic hit;
  always_comb begin
    if (op == jrpq_pkg::OP_INSERT) begin
      hit = jrpq_pkg::goes_before(job, rd_data);
    end else begin
      hit = (rd_data.id == job.id);
    end
  end

  // read address: scan reads idx, insert shift reads idx-1 (moving up),
  // remove shift reads idx+1 (moving down)
  always_comb begin
    rd_addr = idx[jrpq_pkg::AW-1:0];
    if (state == S_SHIFT && op == jrpq_pkg::OP_INSERT) begin
      rd_addr = prev[jrpq_pkg::AW-1:0];
    end else if (state == S_SHIFT) begin
      rd_addr = jrpq_pkg::AW'(idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      wr_en     <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op  <= opcode;
            job <= '{id: request_id, imm: immediate, prio: priority_req,
                     time_s: submit_time};
            idx <= '0;
            rd_pend <= 1'b0;
            if (opcode == jrpq_pkg::OP_INSERT && count == jrpq_pkg::CW'(jrpq_pkg::DEPTH)) begin
              res_status <= jrpq_pkg::ST_FULL; res_position <= '0; state <= S_DONE;
            end else if (opcode != jrpq_pkg::OP_INSERT && opcode != jrpq_pkg::OP_REMOVE &&
                         opcode != jrpq_pkg::OP_FIND) begin
              res_status <= jrpq_pkg::ST_OK; res_position <= '0; state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_pend && hit) begin
            pos <= prev;
            rd_pend <= 1'b0;
            if (op == jrpq_pkg::OP_FIND) begin
              res_status <= jrpq_pkg::ST_OK; res_position <= 6'(prev); state <= S_DONE;
            end else if (op == jrpq_pkg::OP_INSERT) begin
              idx <= count; state <= S_SHIFT;
            end else begin
              idx <= prev; state <= S_SHIFT;
            end
          end else if (idx == count) begin
            rd_pend <= 1'b0;
            if (op == jrpq_pkg::OP_INSERT) begin
              pos <= count; idx <= count; state <= S_SHIFT;
            end else begin
              res_status <= jrpq_pkg::ST_NOT_FOUND; res_position <= '0; state <= S_DONE;
            end
          end else begin
            rd_pend <= 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_SHIFT: begin
          // insert: move entry idx-1 to idx until idx==pos
          // remove: move entry idx+1 to idx until idx==count-1
          if (op == jrpq_pkg::OP_INSERT) begin
            if (idx == pos) begin
              wr_en <= 1'b1; wr_addr <= jrpq_pkg::AW'(pos); wr_data <= job;
              count <= count + 1'b1; res_status <= jrpq_pkg::ST_OK;
              res_position <= 6'(pos); state <= S_WRITE;
            end else begin
              state <= S_WRITE;
            end
          end else begin
            if (idx == count - 1'b1) begin
              count <= count - 1'b1; res_status <= jrpq_pkg::ST_OK;
              res_position <= 6'(pos); state <= S_DONE;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (wr_en) begin
            state <= S_DONE;    // final insert write issued
          end else begin
            wr_en   <= 1'b1;
            wr_addr <= idx[jrpq_pkg::AW-1:0];
            wr_data <= rd_data;
            idx     <= (op == jrpq_pkg::OP_INSERT) ? prev : idx + 1'b1;
            state   <= S_SHIFT;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            status    <= res_status;
            position  <= res_position;
            occupancy <= 7'(count);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no result while an item is still in work
  a_out_only_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> state == S_IDLE)
    else $error("result raised outside idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= jrpq_pkg::CW'(jrpq_pkg::DEPTH))
    else $error("count past depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> $past(state == S_SHIFT))
    else $error("count changed outside shift");

endmodule

[sim/tb_job_request_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_job_request_priority_queue
// checks the sorted job queue: directed edge cases, then random traffic
// predicted by an in-bench sorted array, under several idle/stall mixes
// ----------------------------------------------------------------------------

// expected-result store plus a model of the queue contents
class jrpq_scoreboard;
  jrpq_pkg::job_t entries[$];
  logic [14:0] pending[$];
  int errors;
  int checked;

  // later by time, then by larger id
  function bit is_newer(jrpq_pkg::job_t a, jrpq_pkg::job_t b);
    if (a.time_s != b.time_s) return a.time_s > b.time_s;
    return a.id > b.id;
  endfunction

  function bit ranks_ahead(jrpq_pkg::job_t a, jrpq_pkg::job_t b);
    if (a.imm) return b.imm ? is_newer(a, b) : 1'b1;
    if (b.imm) return 1'b0;
    if (a.prio == b.prio) return !is_newer(a, b);
    return a.prio < b.prio;
  endfunction

  function void note_item(logic [1:0] op, jrpq_pkg::job_t j);
    logic [1:0] st;
    int pos;
    int i;
    st = jrpq_pkg::ST_OK;
    pos = 0;
    if (op == jrpq_pkg::OP_INSERT) begin
      if (entries.size() >= jrpq_pkg::DEPTH) begin
        st = jrpq_pkg::ST_FULL;
      end else begin
        for (i = 0; i < entries.size(); i++)
          if (ranks_ahead(j, entries[i])) break;
        entries.insert(i, j);
        pos = i;
      end
    end else if (op == jrpq_pkg::OP_REMOVE || op == jrpq_pkg::OP_FIND) begin
      for (i = 0; i < entries.size(); i++)
        if (entries[i].id == j.id) break;
      if (i == entries.size()) begin
        st = jrpq_pkg::ST_NOT_FOUND;
      end else begin
        pos = i;
        if (op == jrpq_pkg::OP_REMOVE) entries.delete(i);
      end
    end
    pending.push_back({st, 6'(pos), 7'(entries.size())});
  endfunction

  function void check_result(logic [1:0] st, logic [5:0] pos, logic [6:0] occ);
    logic [14:0] exp;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %0d/%0d/%0d", st, pos, occ);
      return;
    end
    exp = pending.pop_front();
    if (exp !== {st, pos, occ}) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp st=%0d pos=%0d occ=%0d got st=%0d pos=%0d occ=%0d",
                 exp[14:13], exp[12:7], exp[6:0], st, pos, occ);
    end
  endfunction
endclass

module tb_job_request_priority_queue;

  localparam logic [1:0] OP_UNUSED = 2'd3;  // no operation, must change nothing

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = jrpq_pkg::OP_INSERT;
  logic [19:0] request_id = '0;
  logic        immediate = 1'b0;
  logic [5:0]  priority_req = '0;
  logic [31:0] submit_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [5:0]  position;
  logic [6:0]  occupancy;

  jrpq_scoreboard sb = new();
  int send_idle_pct = 0;   // chance the sender sits out a cycle
  int recv_stall_pct = 0;  // chance the receiver stalls a cycle
  int cycles = 0;
  int sent = 0;

  always #5 clk = ~clk;

  job_request_priority_queue u_dut (.*);

  // hard stop: covers the worst item with 87% idle/stall slack over ~400 items
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("timeout");
      $display("tb_job_request_priority_queue NOT OK");
      $finish;
    end
  end

  // result side: check at the rising edge, pick the next stall at the falling one
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(status, position, occupancy);

  always @(negedge clk)
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

  // present one item, hold it until taken
  task automatic send_item(logic [1:0] op, logic [19:0] id, logic imm,
                           logic [5:0] prio, logic [31:0] t);
    jrpq_pkg::job_t j;
    while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    request_id <= id;
    immediate <= imm;
    priority_req <= prio;
    submit_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    j = '{id: id, imm: imm, prio: prio, time_s: t};
    sb.note_item(op, j);
    sent++;
    @(negedge clk);
  endtask

  // wait for every expected result to drain
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (140) @(negedge clk);
  endtask

  // mostly well-formed traffic: inserts with fresh ids, remove/find of queued ids
  task automatic random_items(int n);
    logic [1:0] op;
    logic [19:0] id;
    int k;
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      id = 20'($urandom);
      if (r < 45) begin
        op = jrpq_pkg::OP_INSERT;
      end else if (r < 95) begin
        op = (r < 70) ? jrpq_pkg::OP_REMOVE : jrpq_pkg::OP_FIND;
        if (sb.entries.size() > 0 && $urandom_range(9) != 0) begin
          k = $urandom_range(sb.entries.size() - 1);
          id = sb.entries[k].id;
        end
      end else begin
        op = OP_UNUSED;
      end
      // narrow ranges now and then to force priority and time ties
      send_item(op, id, 1'($urandom_range(1)),
                ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(39)),
                ($urandom_range(2) == 0) ? 32'($urandom_range(3)) : 32'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-store misses, extremes, ties, duplicates, unused opcode
    send_item(jrpq_pkg::OP_FIND, 20'd5, 1'b0, 6'd0, 32'd0);
    send_item(jrpq_pkg::OP_REMOVE, 20'hFFFFF, 1'b1, 6'd63, '1);
    send_item(OP_UNUSED, 20'd0, 1'b0, 6'd0, 32'd0);
    send_item(jrpq_pkg::OP_INSERT, 20'd10, 1'b0, 6'd5, 32'd100);
    send_item(jrpq_pkg::OP_INSERT, 20'd11, 1'b0, 6'd5, 32'd100);  // equal prio/time
    send_item(jrpq_pkg::OP_INSERT, 20'd9, 1'b0, 6'd5, 32'd100);
    send_item(jrpq_pkg::OP_INSERT, 20'd12, 1'b0, 6'd0, 32'hFFFFFFFF);
    send_item(jrpq_pkg::OP_INSERT, 20'hFFFFF, 1'b0, 6'd63, 32'd0);
    send_item(jrpq_pkg::OP_INSERT, 20'd20, 1'b1, 6'd0, 32'd50);
    send_item(jrpq_pkg::OP_INSERT, 20'd21, 1'b1, 6'd39, 32'd50);   // imm tie, larger id
    send_item(jrpq_pkg::OP_INSERT, 20'd19, 1'b1, 6'd0, 32'd50);
    send_item(jrpq_pkg::OP_INSERT, 20'd0, 1'b1, 6'd63, 32'hFFFFFFFF);
    send_item(jrpq_pkg::OP_INSERT, 20'd10, 1'b0, 6'd1, 32'd7);      // duplicate id
    send_item(jrpq_pkg::OP_FIND, 20'd10, 1'b0, 6'd0, 32'd0);
    send_item(jrpq_pkg::OP_REMOVE, 20'd10, 1'b0, 6'd0, 32'd0);
    send_item(jrpq_pkg::OP_FIND, 20'd10, 1'b0, 6'd0, 32'd0);
    send_item(jrpq_pkg::OP_REMOVE, 20'd0, 1'b0, 6'd0, 32'd0);
    send_item(OP_UNUSED, 20'h5A5A5, 1'b1, 6'd42, 32'h12345678);
    // fill to full and one more for the full case, then drain a few
    while (sb.entries.size() < jrpq_pkg::DEPTH)
      send_item(jrpq_pkg::OP_INSERT, 20'($urandom), 1'($urandom),
                6'($urandom_range(39)), $urandom);
    send_item(jrpq_pkg::OP_INSERT, 20'd77, 1'b1, 6'd0, 32'd1);
    send_item(jrpq_pkg::OP_FIND, sb.entries[jrpq_pkg::DEPTH-1].id, 1'b0, 6'd0, 32'd0);
    send_item(jrpq_pkg::OP_REMOVE, sb.entries[jrpq_pkg::DEPTH-1].id, 1'b0, 6'd0, 32'd0);
    send_item(jrpq_pkg::OP_REMOVE, sb.entries[0].id, 1'b0, 6'd0, 32'd0);
    drain();  // sender holds off until all results are back

    // random phases under different idle/stall mixes
    send_idle_pct = 0;  recv_stall_pct = 0;  random_items(80);
    send_idle_pct = 87; recv_stall_pct = 0;  random_items(80);
    drain();
    send_idle_pct = 0;  recv_stall_pct = 87; random_items(80);
    send_idle_pct = 35; recv_stall_pct = 35; random_items(80);
    send_idle_pct = 0;  recv_stall_pct = 0;
    drain();

    $display("covered %0d items, %0d results checked, incl. full store and ties",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_job_request_priority_queue OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("tb_job_request_priority_queue NOT OK");
    end
    $finish;
  end

endmodule
